// ----- rtl/core/shell_word_splitter_assert.svh -----
`ifndef SHELL_WORD_SPLITTER_ASSERT_SVH
`define SHELL_WORD_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SWS_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("sws assertion failed: name");

// next-cycle implication, checked out of reset
`define SWS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("sws assertion failed: name");

`endif

// ----- rtl/core/sws_pkg.sv -----
`timescale 1ns / 1ps

package sws_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN      = 3'd0,
        MODE_PLAIN_ESC  = 3'd1,
        MODE_SINGLE     = 3'd2,
        MODE_DOUBLE     = 3'd3,
        MODE_DOUBLE_ESC = 3'd4
    } t_mode;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    localparam logic [1:0] WARN_NONE   = 2'd0;
    localparam logic [1:0] WARN_SINGLE = 2'd1;
    localparam logic [1:0] WARN_DOUBLE = 2'd2;
    localparam logic [1:0] WARN_BSLASH = 2'd3;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_item;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       word_end;
        logic       line_end;
        logic [1:0] warning;
    } t_result;

endpackage

// ----- rtl/core/sws_item_if.sv -----
`timescale 1ns / 1ps

interface sws_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

// ----- rtl/core/sws_result_if.sv -----
`timescale 1ns / 1ps

interface sws_result_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] out_char;
    logic       word_end;
    logic       line_end;
    logic [1:0] warning;

    modport source (
        output valid, output has_char, output out_char, output word_end,
        output line_end, output warning, input ready
    );
    modport sink (
        input valid, input has_char, input out_char, input word_end,
        input line_end, input warning, output ready
    );
endinterface

// ----- rtl/core/sws_fsm.sv -----
`timescale 1ns / 1ps
`include "shell_word_splitter_assert.svh"

module sws_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  sws_pkg::t_item  i_item,
    output logic            o_emit,
    output sws_pkg::t_result o_result
);

    sws_pkg::t_mode r_mode;
    sws_pkg::t_mode n_mode;
    logic           r_word_open;
    logic           n_word_open;
    logic           is_space;
    logic [7:0]     c;

    assign c = i_item.in_byte;

    always_comb begin
        is_space = c inside {sws_pkg::CH_SPACE, sws_pkg::CH_TAB, sws_pkg::CH_LF,
                             sws_pkg::CH_VT, sws_pkg::CH_FF, sws_pkg::CH_CR};
    end

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_word_open = r_word_open;
        if (i_item.action == sws_pkg::ACT_EOL) begin
            n_mode      = sws_pkg::MODE_PLAIN;
            n_word_open = 1'b0;
        end else begin
            case (r_mode)
                sws_pkg::MODE_PLAIN_ESC: begin
                    n_mode      = sws_pkg::MODE_PLAIN;
                    n_word_open = 1'b1;
                end
                sws_pkg::MODE_SINGLE: begin
                    if (c == sws_pkg::CH_SQUOTE) begin
                        n_mode = sws_pkg::MODE_PLAIN;
                    end
                end
                sws_pkg::MODE_DOUBLE: begin
                    if (c == sws_pkg::CH_DQUOTE) begin
                        n_mode = sws_pkg::MODE_PLAIN;
                    end else if (c == sws_pkg::CH_BSLASH) begin
                        n_mode = sws_pkg::MODE_DOUBLE_ESC;
                    end
                end
                sws_pkg::MODE_DOUBLE_ESC: begin
                    n_mode = sws_pkg::MODE_DOUBLE;
                end
                default: begin
                    n_mode = sws_pkg::MODE_PLAIN;
                    if (c == sws_pkg::CH_SQUOTE) begin
                        n_word_open = 1'b1;
                        n_mode      = sws_pkg::MODE_SINGLE;
                    end else if (c == sws_pkg::CH_DQUOTE) begin
                        n_word_open = 1'b1;
                        n_mode      = sws_pkg::MODE_DOUBLE;
                    end else if (c == sws_pkg::CH_BSLASH) begin
                        n_mode = sws_pkg::MODE_PLAIN_ESC;
                    end else if (is_space) begin
                        n_word_open = 1'b0;
                    end else begin
                        n_word_open = 1'b1;
                    end
                end
            endcase
        end
    end

    // result of the current item
    always_comb begin
        o_emit   = 1'b0;
        o_result = '0;
        if (i_item.action == sws_pkg::ACT_EOL) begin
            o_emit            = 1'b1;
            o_result.line_end = 1'b1;
            o_result.word_end = r_word_open;
            case (r_mode)
                sws_pkg::MODE_SINGLE:     o_result.warning = sws_pkg::WARN_SINGLE;
                sws_pkg::MODE_DOUBLE:     o_result.warning = sws_pkg::WARN_DOUBLE;
                sws_pkg::MODE_DOUBLE_ESC: o_result.warning = sws_pkg::WARN_DOUBLE;
                sws_pkg::MODE_PLAIN_ESC:  o_result.warning = sws_pkg::WARN_BSLASH;
                default:                  o_result.warning = sws_pkg::WARN_NONE;
            endcase
        end else begin
            case (r_mode)
                sws_pkg::MODE_PLAIN_ESC, sws_pkg::MODE_DOUBLE_ESC: begin
                    o_emit = 1'b1;
                end
                sws_pkg::MODE_SINGLE: begin
                    o_emit = (c != sws_pkg::CH_SQUOTE);
                end
                sws_pkg::MODE_DOUBLE: begin
                    o_emit = (c != sws_pkg::CH_DQUOTE) && (c != sws_pkg::CH_BSLASH);
                end
                default: begin
                    if (c == sws_pkg::CH_SQUOTE || c == sws_pkg::CH_DQUOTE
                            || c == sws_pkg::CH_BSLASH) begin
                        o_emit = 1'b0;
                    end else if (is_space) begin
                        o_emit            = r_word_open;
                        o_result.word_end = r_word_open;
                    end else begin
                        o_emit = 1'b1;
                    end
                end
            endcase
            if (o_emit && !o_result.word_end) begin
                o_result.has_char = 1'b1;
                o_result.out_char = c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sws_pkg::MODE_PLAIN;
            r_word_open <= 1'b0;
        end else if (i_advance) begin
            r_mode      <= n_mode;
            r_word_open <= n_word_open;
        end
    end

    `SWS_ASSERT_NEXT(a_eol_clears_state, i_clk, i_rst_n,
        i_advance && i_item.action == sws_pkg::ACT_EOL,
        r_mode == sws_pkg::MODE_PLAIN && !r_word_open)
    `SWS_ASSERT_NOW(a_char_opens_word, i_clk, i_rst_n,
        i_advance && o_result.has_char && r_mode == sws_pkg::MODE_PLAIN,
        n_word_open)
    `SWS_ASSERT_NOW(a_word_end_needs_open, i_clk, i_rst_n,
        o_emit && o_result.word_end, r_word_open)

endmodule

// ----- rtl/core/shell_word_splitter.sv -----
`timescale 1ns / 1ps
// shell word splitter
// i_in carries one transaction per line byte (action 0, in_byte) and one
// end-of-line transaction (action 1) after the last byte of each line.
// o_out carries the results: one per byte that joins a word (has_char,
// out_char), one per whitespace that closes an open word (word_end), and
// one per end-of-line transaction (line_end, word_end if a word was open,
// warning for an unmatched single quote, double quote or backslash).
// quotes and backslashes that quote or escape, and whitespace outside a word, give no transaction.
// the input register holds a transaction and the result register its result.
// throughput: one input transaction per clock while i_in.ready is high; the
// quote-mode state machine decides each byte combinationally between them.
// a held result does not stop input: the input register keeps taking bytes
// that give no result, and i_in.ready drops only while a byte with a result
// waits behind a held result.
// reset (synchronous, active low) empties both registers and returns the
// splitter to plain mode with no word open.
`include "shell_word_splitter_assert.svh"

module shell_word_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sws_item_if.sink    i_in,
    sws_result_if.source o_out
);

    logic             r_in_valid;
    sws_pkg::t_item   r_in;
    logic             r_out_valid;
    sws_pkg::t_result r_out;
    logic             emit;
    sws_pkg::t_result result;
    logic             out_free;
    logic             advance;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    sws_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_emit    (emit),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action  <= i_in.action;
            r_in.in_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.has_char = r_out.has_char;
    assign o_out.out_char = r_out.out_char;
    assign o_out.word_end = r_out.word_end;
    assign o_out.line_end = r_out.line_end;
    assign o_out.warning  = r_out.warning;

    `SWS_ASSERT_NOW(a_warn_only_at_eol, i_clk, i_rst_n,
        r_out_valid && !r_out.line_end, r_out.warning == sws_pkg::WARN_NONE)
    `SWS_ASSERT_NOW(a_char_excludes_ends, i_clk, i_rst_n,
        r_out_valid && r_out.has_char, !r_out.word_end && !r_out.line_end)
    `SWS_ASSERT_NOW(a_stall_needs_full_in, i_clk, i_rst_n,
        !i_in.ready, r_in_valid && r_out_valid && emit)

endmodule
